/* sv/bpfa_pkg.sv */
// Shared constants, codes and control types of the bitmap page frame allocator.
`default_nettype none
package bpfa_pkg;

   localparam int MAX_PAGES_DEF = 512;
   localparam int WORD_BITS     = 32;
   localparam int WORD_LSB      = 5;
   localparam int CFG_W         = 10;
   localparam int PAGE_IO_W     = 9;
   localparam int FUNC_W        = 2;
   localparam int STATUS_W      = 2;
   localparam int CSR_IDX_W     = 1;
   localparam logic [CFG_W-1:0] COUNT_MAX = 10'd1023;

   localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FN_INIT  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_USER_PAGE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PAGES     = 1'd1;

   typedef struct packed {
      logic                load;
      logic                scan_begin;
      logic                scan_next;
      logic                free_read;
      logic                alloc_take;
      logic                free_set;
      logic                init_begin;
      logic                init_write;
      logic                finish;
      logic [STATUS_W-1:0] status;
   } bpfa_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              count_zero;
      logic              scan_empty;
      logic              scan_last;
      logic              word_hit;
      logic              range_bad;
      logic              init_last;
   } bpfa_sts_type;

endpackage
`default_nettype wire

/* sv/bpfa_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bpfa_ram
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* sv/bpfa_ctrl.sv */
// Request sequencer of the page frame allocator.
`default_nettype none
module bpfa_ctrl
   import bpfa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire bpfa_sts_type sts,
   output bpfa_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_SCAN     = 3'd2;
   localparam logic [2:0] ST_FREE_CHK = 3'd3;
   localparam logic [2:0] ST_INIT     = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (sts.func)
               FN_ALLOC: begin
                  if (sts.count_zero || sts.scan_empty) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_NONE;
                     state_in   = ST_IDLE;
                  end else begin
                     cmd.scan_begin = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               FN_FREE: begin
                  if (sts.range_bad) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_RANGE;
                     state_in   = ST_IDLE;
                  end else begin
                     cmd.free_read = 1'b1;
                     state_in      = ST_FREE_CHK;
                  end
               end
               FN_INIT: begin
                  cmd.init_begin = 1'b1;
                  state_in       = ST_INIT;
               end
               default: begin
                  cmd.finish = 1'b1;
                  cmd.status = ST_OK;
                  state_in   = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            if (sts.word_hit) begin
               cmd.alloc_take = 1'b1;
               cmd.finish     = 1'b1;
               cmd.status     = ST_OK;
               state_in       = ST_IDLE;
            end else if (sts.scan_last) begin
               cmd.finish = 1'b1;
               cmd.status = ST_NONE;
               state_in   = ST_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_FREE_CHK: begin
            cmd.free_set = 1'b1;
            cmd.finish   = 1'b1;
            cmd.status   = ST_OK;
            state_in     = ST_IDLE;
         end
         ST_INIT: begin
            cmd.init_write = 1'b1;
            if (sts.init_last) begin
               cmd.finish = 1'b1;
               cmd.status = ST_OK;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_DISPATCH))
      else $error("accepted item did not reach dispatch");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (state_ff == ST_IDLE))
      else $error("finished item did not return to idle");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      (cmd.alloc_take || cmd.free_set || cmd.init_write) |->
         (state_ff == ST_SCAN || state_ff == ST_FREE_CHK || state_ff == ST_INIT))
      else $error("bitmap write outside a writing state");

endmodule
`default_nettype wire

/* sv/bpfa_dp.sv */
// Datapath: config registers, bitmap memory, free count and result registers.
`default_nettype none
module bpfa_dp
   import bpfa_pkg::*;
#(
   parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [FUNC_W-1:0]    req_func,
   input  wire logic [PAGE_IO_W-1:0] req_page,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wr_data,
   input  wire bpfa_cmd_type         cmd,
   output bpfa_sts_type              sts,
   output logic                      rsp_valid,
   output logic [PAGE_IO_W-1:0]      rsp_page_out,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [CFG_W-1:0]          rsp_free_count
);

   localparam int NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int WCNT_W    = $clog2(NUM_WORDS + 1);
   localparam int PAGE_W    = $clog2(MAX_PAGES);
   localparam int CMP_W     = ((PAGE_W > CFG_W) ? PAGE_W : CFG_W) + 1;
   localparam int FOUND_W   = WIDX + WORD_LSB;

   function automatic logic [WORD_LSB-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
      logic [WORD_LSB-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = WORD_LSB'(i);
         end
      end
      return r;
   endfunction

   logic [CFG_W-1:0]     fup_ff, fup_in;
   logic [CFG_W-1:0]     tot_ff, tot_in;
   logic [FUNC_W-1:0]    func_ff, func_in;
   logic [PAGE_IO_W-1:0] page_ff, page_in;
   logic [CFG_W-1:0]     count_ff, count_in;
   logic [WCNT_W-1:0]    ptr_ff, ptr_in;
   logic [WIDX-1:0]      chk_ff, chk_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic                 valid_ff [NUM_WORDS];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PAGE_IO_W-1:0] rsp_page_out_ff, rsp_page_out_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [CFG_W-1:0]     rsp_free_count_ff, rsp_free_count_in;

   logic [CMP_W-1:0]     lim_wide;
   logic [CFG_W-1:0]     lim;
   logic [CMP_W-1:0]     start_wide;
   logic [CMP_W-1:0]     end_wide;
   logic [WCNT_W-1:0]    scan_start;
   logic [WCNT_W-1:0]    scan_end;
   logic [CFG_W-1:0]     init_count;

   logic                 ram_wr_en;
   logic [WIDX-1:0]      ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [WIDX-1:0]      ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   logic [WORD_BITS-1:0] word;
   logic [WORD_LSB-1:0]  lsb;
   logic [FOUND_W-1:0]   found_page;
   logic [WORD_BITS-1:0] bit_mask;
   logic [WORD_BITS-1:0] init_mask;
   logic [CMP_W-1:0]     init_base;
   logic [CMP_W-1:0]     pg_tmp;

   // page limit and scan window
   always_comb begin
      lim_wide = (CMP_W'(tot_ff) > CMP_W'(MAX_PAGES)) ? CMP_W'(MAX_PAGES) : CMP_W'(tot_ff);
      lim      = CFG_W'(lim_wide);
      start_wide = CMP_W'(fup_ff >> WORD_LSB);
      if (start_wide > CMP_W'(NUM_WORDS)) begin
         start_wide = CMP_W'(NUM_WORDS);
      end
      end_wide = (lim_wide + CMP_W'(WORD_BITS - 1)) >> WORD_LSB;
      if (end_wide > CMP_W'(NUM_WORDS)) begin
         end_wide = CMP_W'(NUM_WORDS);
      end
      scan_start = WCNT_W'(start_wide);
      scan_end   = WCNT_W'(end_wide);
      init_count = (lim > fup_ff) ? (lim - fup_ff) : '0;
   end

   assign word       = ram_rd_data & {WORD_BITS{rd_valid_ff}};
   assign lsb        = lowest_bit(word);
   assign found_page = {chk_ff, lsb};
   assign bit_mask   = WORD_BITS'(1) << page_ff[WORD_LSB-1:0];

   // free bits of word ptr_ff after init
   always_comb begin
      init_base = CMP_W'({ptr_ff, {WORD_LSB{1'b0}}});
      init_mask = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         pg_tmp = init_base + CMP_W'(i);
         init_mask[i] = (pg_tmp >= CMP_W'(fup_ff)) && (pg_tmp < lim_wide);
      end
   end

   always_comb begin
      sts.func       = func_ff;
      sts.count_zero = (count_ff == '0);
      sts.scan_empty = (start_wide >= end_wide);
      sts.scan_last  = (ptr_ff >= scan_end);
      sts.word_hit   = |word;
      sts.range_bad  = (CMP_W'(page_ff) < CMP_W'(fup_ff)) || (CMP_W'(page_ff) >= lim_wide);
      sts.init_last  = (ptr_ff == WCNT_W'(NUM_WORDS - 1));
   end

   // memory ports
   always_comb begin
      ram_rd_en   = cmd.scan_begin || cmd.scan_next || cmd.free_read;
      ram_rd_addr = WIDX'(ptr_ff);
      if (cmd.scan_begin) begin
         ram_rd_addr = WIDX'(scan_start);
      end else if (cmd.free_read) begin
         ram_rd_addr = WIDX'(page_ff >> WORD_LSB);
      end
      ram_wr_en   = cmd.alloc_take || cmd.free_set || cmd.init_write;
      ram_wr_addr = chk_ff;
      ram_wr_data = word | bit_mask;
      if (cmd.alloc_take) begin
         ram_wr_data = word & ~(WORD_BITS'(1) << lsb);
      end else if (cmd.init_write) begin
         ram_wr_addr = WIDX'(ptr_ff);
         ram_wr_data = init_mask;
      end
   end

   always_comb begin
      fup_in      = fup_ff;
      tot_in      = tot_ff;
      func_in     = func_ff;
      page_in     = page_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      chk_in      = chk_ff;
      rd_valid_in = rd_valid_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_FIRST_USER_PAGE: fup_in = csr_wr_data;
            CSR_TOTAL_PAGES:     tot_in = csr_wr_data;
            default: ;
         endcase
      end
      if (cmd.load) begin
         func_in = req_func;
         page_in = req_page;
      end
      if (ram_rd_en) begin
         rd_valid_in = valid_ff[ram_rd_addr];
      end
      if (cmd.scan_begin) begin
         chk_in = WIDX'(scan_start);
         ptr_in = scan_start + WCNT_W'(1);
      end
      if (cmd.scan_next) begin
         chk_in = WIDX'(ptr_ff);
         ptr_in = ptr_ff + WCNT_W'(1);
      end
      if (cmd.free_read) begin
         chk_in = WIDX'(page_ff >> WORD_LSB);
      end
      if (cmd.init_begin) begin
         ptr_in   = '0;
         count_in = init_count;
      end
      if (cmd.init_write) begin
         ptr_in = ptr_ff + WCNT_W'(1);
      end
      if (cmd.alloc_take) begin
         count_in = count_ff - CFG_W'(1);
      end
      // double free leaves the count alone
      if (cmd.free_set && ((word & bit_mask) == '0) && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + CFG_W'(1);
      end

      rsp_valid_in      = cmd.finish;
      rsp_page_out_in   = rsp_page_out_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_free_count_in = rsp_free_count_ff;
      if (cmd.finish) begin
         rsp_page_out_in   = cmd.alloc_take ? PAGE_IO_W'(found_page) : '0;
         rsp_status_in     = cmd.status;
         rsp_free_count_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fup_ff       <= '0;
         tot_ff       <= CFG_W'(512);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_WORDS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         fup_ff       <= fup_in;
         tot_ff       <= tot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_wr_en) begin
            valid_ff[ram_wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff           <= func_in;
      page_ff           <= page_in;
      ptr_ff            <= ptr_in;
      chk_ff            <= chk_in;
      rd_valid_ff       <= rd_valid_in;
      rsp_page_out_ff   <= rsp_page_out_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_free_count_ff <= rsp_free_count_in;
   end

   bpfa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_page_out   = rsp_page_out_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_free_count = rsp_free_count_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   a_fail_zero_page: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_page_out_ff == '0))
      else $error("failed item reports a page");

   a_range_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_RANGE) |-> (rsp_free_count_ff == count_ff))
      else $error("rejected free changed the count");

endmodule
`default_nettype wire

/* sv/bitmap_page_frame_allocator.sv */
// Top level of the bitmap page frame allocator.
// One item at a time; busy is high from accept until the result strobe.
// Rejected frees, allocates refused at dispatch, unused code: result registered from dispatch; free: from the check.
// Allocate: scans words from the word of first_user_page (up to MAX_PAGES/32), one bitmap word read per cycle.
// Init: writes every bitmap word, one bitmap word written per cycle. Results cannot be stalled.
// Synchronous reset: map reads as all zero, count 0, first_user_page 0, total_pages 512.
`default_nettype none
module bitmap_page_frame_allocator
   import bpfa_pkg::*;
#(
   parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [FUNC_W-1:0]    req_func,
   input  wire logic [PAGE_IO_W-1:0] req_page,
   output logic                      rsp_valid,
   output logic [PAGE_IO_W-1:0]      rsp_page_out,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [CFG_W-1:0]          rsp_free_count,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wr_data
);

   bpfa_cmd_type cmd;
   bpfa_sts_type sts;

   bpfa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   bpfa_dp #(
      .MAX_PAGES (MAX_PAGES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_func       (req_func),
      .req_page       (req_page),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_page_out   (rsp_page_out),
      .rsp_status     (rsp_status),
      .rsp_free_count (rsp_free_count)
   );

endmodule
`default_nettype wire

/* verif/bitmap_page_frame_allocator_tb.sv */
// Self-checking testbench of the bitmap page frame allocator: directed table, then random phases.
`default_nettype none
module bitmap_page_frame_allocator_tb;
   import bpfa_pkg::*;

   localparam int MAP_PAGES   = MAX_PAGES_DEF;
   localparam int NUM_WORDS   = MAP_PAGES / WORD_BITS;
   localparam int RAND_ITEMS  = 1450;
   localparam int GAP_MAX     = 18;
   localparam int CYCLE_LIMIT = 500000;
   localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

   typedef struct packed {
      logic [PAGE_IO_W-1:0] page_out;
      logic [STATUS_W-1:0]  status;
      logic [CFG_W-1:0]     free_count;
   } alloc_result_type;

   typedef enum logic {RK_ITEM, RK_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [FUNC_W-1:0]    func;
      logic [PAGE_IO_W-1:0] page;
      logic [CSR_IDX_W-1:0] idx;
      logic [CFG_W-1:0]     data;
      logic                 fixed;   // expected result typed in below
      alloc_result_type     want;
   } dir_row_type;

   localparam int NUM_DIRECTED = 30;

   // Rows with fixed = 0 are checked against the predictor only.
   dir_row_type directed_rows [NUM_DIRECTED] = '{
      '{RK_ITEM, FN_ALLOC,  9'd0,   1'd0, 10'd0, 1'b1, '{9'd0, ST_NONE,  10'd0}},
      '{RK_ITEM, FN_FREE,   9'd5,   1'd0, 10'd0, 1'b1, '{9'd0, ST_OK,    10'd1}},
      '{RK_ITEM, FN_FREE,   9'd5,   1'd0, 10'd0, 1'b1, '{9'd0, ST_OK,    10'd1}},
      '{RK_ITEM, FN_ALLOC,  9'd0,   1'd0, 10'd0, 1'b1, '{9'd5, ST_OK,    10'd0}},
      '{RK_ITEM, FN_UNUSED, 9'd511, 1'd0, 10'd0, 1'b1, '{9'd0, ST_OK,    10'd0}},
      '{RK_ITEM, FN_INIT,   9'd0,   1'd0, 10'd0, 1'b1, '{9'd0, ST_OK,    10'd512}},
      '{RK_ITEM, FN_ALLOC,  9'd0,   1'd0, 10'd0, 1'b1, '{9'd0, ST_OK,    10'd511}},
      '{RK_ITEM, FN_ALLOC,  9'd0,   1'd0, 10'd0, 1'b1, '{9'd1, ST_OK,    10'd510}},
      '{RK_ITEM, FN_FREE,   9'd511, 1'd0, 10'd0, 1'b1, '{9'd0, ST_OK,    10'd510}},
      '{RK_ITEM, FN_FREE,   9'd0,   1'd0, 10'd0, 1'b1, '{9'd0, ST_OK,    10'd511}},
      '{RK_CSR,  FN_ALLOC,  9'd0, CSR_FIRST_USER_PAGE, 10'd500, 1'b0, '0},
      '{RK_ITEM, FN_INIT,   9'd0,   1'd0, 10'd0, 1'b0, '0},
      '{RK_ITEM, FN_FREE,   9'd499, 1'd0, 10'd0, 1'b1, '{9'd0, ST_RANGE, 10'd12}},
      '{RK_ITEM, FN_FREE,   9'd0,   1'd0, 10'd0, 1'b1, '{9'd0, ST_RANGE, 10'd12}},
      '{RK_CSR,  FN_ALLOC,  9'd0, CSR_TOTAL_PAGES, 10'd0, 1'b0, '0},
      '{RK_ITEM, FN_FREE,   9'd505, 1'd0, 10'd0, 1'b1, '{9'd0, ST_RANGE, 10'd12}},
      '{RK_ITEM, FN_ALLOC,  9'd0,   1'd0, 10'd0, 1'b0, '0},
      '{RK_CSR,  FN_ALLOC,  9'd0, CSR_TOTAL_PAGES, 10'd1023, 1'b0, '0},
      '{RK_ITEM, FN_ALLOC,  9'd0,   1'd0, 10'd0, 1'b0, '0},
      '{RK_CSR,  FN_ALLOC,  9'd0, CSR_FIRST_USER_PAGE, 10'd510, 1'b0, '0},
      '{RK_ITEM, FN_ALLOC,  9'd0,   1'd0, 10'd0, 1'b0, '0},
      '{RK_CSR,  FN_ALLOC,  9'd0, CSR_FIRST_USER_PAGE, 10'd1023, 1'b0, '0},
      '{RK_ITEM, FN_INIT,   9'd0,   1'd0, 10'd0, 1'b1, '{9'd0, ST_OK,    10'd0}},
      '{RK_ITEM, FN_FREE,   9'd511, 1'd0, 10'd0, 1'b1, '{9'd0, ST_RANGE, 10'd0}},
      '{RK_ITEM, FN_ALLOC,  9'd0,   1'd0, 10'd0, 1'b1, '{9'd0, ST_NONE,  10'd0}},
      '{RK_ITEM, FN_UNUSED, 9'd0,   1'd0, 10'd0, 1'b0, '0},
      '{RK_CSR,  FN_ALLOC,  9'd0, CSR_FIRST_USER_PAGE, 10'd0, 1'b0, '0},
      '{RK_CSR,  FN_ALLOC,  9'd0, CSR_TOTAL_PAGES, 10'd512, 1'b0, '0},
      '{RK_ITEM, FN_INIT,   9'd0,   1'd0, 10'd0, 1'b0, '0},
      '{RK_ITEM, FN_FREE,   9'd256, 1'd0, 10'd0, 1'b0, '0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [FUNC_W-1:0]    req_func = '0;
   logic [PAGE_IO_W-1:0] req_page = '0;
   logic                 rsp_valid;
   logic [PAGE_IO_W-1:0] rsp_page_out;
   logic [STATUS_W-1:0]  rsp_status;
   logic [CFG_W-1:0]     rsp_free_count;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wr_data = '0;

   // predictor state
   logic [WORD_BITS-1:0] free_map [NUM_WORDS];
   logic [CFG_W-1:0]     free_cnt;
   logic [CFG_W-1:0]     fup_reg;
   logic [CFG_W-1:0]     tot_reg;

   alloc_result_type     pending_responses [$];
   logic [PAGE_IO_W-1:0] held_pages [$];

   int cycle_count    = 0;
   int mismatches     = 0;
   int items_sent     = 0;
   int allocs_granted = 0;
   int allocs_refused = 0;
   int frees_rejected = 0;
   int csr_writes     = 0;

   bitmap_page_frame_allocator dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_page      (req_page),
      .rsp_valid     (rsp_valid),
      .rsp_page_out  (rsp_page_out),
      .rsp_status    (rsp_status),
      .rsp_free_count(rsp_free_count),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bitmap_page_frame_allocator regression: fail");
         $finish;
      end
   end

   function automatic int page_limit();
      return (int'(tot_reg) > MAP_PAGES) ? MAP_PAGES : int'(tot_reg);
   endfunction

   // Next state of the allocator and the result of one item.
   function automatic alloc_result_type compute_response(input logic [FUNC_W-1:0] f,
                                                         input logic [PAGE_IO_W-1:0] pg);
      alloc_result_type r;
      int               lim;
      int               last_word;
      int               n;
      int               w;
      int               b;
      logic             found;
      r.page_out = '0;
      r.status   = ST_OK;
      lim        = page_limit();
      case (f)
         FN_INIT: begin
            for (w = 0; w < NUM_WORDS; w++) free_map[w] = '0;
            n = 0;
            for (int p = int'(fup_reg); p < lim; p++) begin
               free_map[p / WORD_BITS][p % WORD_BITS] = 1'b1;
               n++;
            end
            free_cnt = (n > int'(COUNT_MAX)) ? COUNT_MAX : CFG_W'(n);
         end
         FN_ALLOC: begin
            found = 1'b0;
            if (free_cnt != '0) begin
               last_word = (lim + WORD_BITS - 1) / WORD_BITS;
               if (last_word > NUM_WORDS) last_word = NUM_WORDS;
               // scan starts at the word of first_user_page; lower bits of it may be stale
               for (w = int'(fup_reg) / WORD_BITS; w < last_word && !found; w++) begin
                  for (b = 0; b < WORD_BITS && !found; b++) begin
                     if (free_map[w][b]) begin
                        free_map[w][b] = 1'b0;
                        free_cnt       = free_cnt - CFG_W'(1);
                        r.page_out     = PAGE_IO_W'(w * WORD_BITS + b);
                        found          = 1'b1;
                     end
                  end
               end
            end
            if (!found) r.status = ST_NONE;
         end
         FN_FREE: begin
            if (pg < fup_reg || int'(pg) >= lim) begin
               r.status = ST_RANGE;
            end else if (!free_map[pg[8:5]][pg[4:0]]) begin
               free_map[pg[8:5]][pg[4:0]] = 1'b1;
               if (free_cnt < COUNT_MAX) free_cnt = free_cnt + CFG_W'(1);
            end
         end
         default: ;
      endcase
      r.free_count = free_cnt;
      return r;
   endfunction

   always @(posedge clock) begin : rsp_check
      alloc_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_responses.size() == 0) begin
            $error("unexpected result: page_out %0d status %0d free_count %0d",
                   rsp_page_out, rsp_status, rsp_free_count);
            mismatches++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_page_out !== want.page_out) begin
               $error("page_out: expected %0d, actual %0d", want.page_out, rsp_page_out);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_free_count !== want.free_count) begin
               $error("free_count: expected %0d, actual %0d", want.free_count, rsp_free_count);
               mismatches++;
            end
         end
      end
   end

   // Offer one item, wait for accept, then an optional gap before the next one.
   task automatic send_item(input logic [FUNC_W-1:0] f, input logic [PAGE_IO_W-1:0] pg,
                            input int gap_max, input logic fixed,
                            input alloc_result_type typed,
                            output alloc_result_type r);
      int gap;
      req_func <= f;
      req_page <= pg;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      r = compute_response(f, pg);
      pending_responses.push_back(fixed ? typed : r);
      items_sent++;
      if (f == FN_ALLOC && r.status == ST_OK) allocs_granted++;
      if (f == FN_ALLOC && r.status == ST_NONE) allocs_refused++;
      if (f == FN_FREE && r.status == ST_RANGE) frees_rejected++;
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
      csr_index   <= idx;
      csr_wr_data <= d;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      if (idx == CSR_FIRST_USER_PAGE) fup_reg = d;
      else tot_reg = d;
      csr_writes++;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CFG_W-1:0] pick_total();
      case ($urandom_range(0, 5))
         0: return 10'd512;
         1: return 10'd1023;
         2: return 10'd0;
         3: return CFG_W'($urandom_range(0, 1023));
         default: return CFG_W'($urandom_range(0, 512));
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_first(input int lim);
      case ($urandom_range(0, 7))
         0: return 10'd0;
         1: return 10'd1023;
         2: return 10'd512;
         3: return CFG_W'($urandom_range(0, 1023));
         4, 5: return CFG_W'($urandom_range(0, 40));
         // tight user range, so allocations run dry
         default: return (lim > 40) ? CFG_W'(lim - int'($urandom_range(1, 40))) : 10'd0;
      endcase
   endfunction

   task automatic run_phase(input int n_items);
      alloc_result_type r;
      int               gap_max;
      int               alloc_w;
      int               roll;
      int               lim;
      int               k;
      logic [FUNC_W-1:0]    f;
      logic [PAGE_IO_W-1:0] pg;
      wait_idle();
      csr_write(CSR_TOTAL_PAGES, pick_total());
      csr_write(CSR_FIRST_USER_PAGE, pick_first(page_limit()));
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      alloc_w = $urandom_range(25, 65);
      // now and then keep the old map so stale bits meet the new registers
      if ($urandom_range(0, 7) != 0) begin
         send_item(FN_INIT, PAGE_IO_W'($urandom_range(0, 511)), gap_max, 1'b0, '0, r);
         held_pages.delete();
      end
      for (int i = 1; i < n_items; i++) begin
         roll = $urandom_range(0, 99);
         lim  = page_limit();
         pg   = PAGE_IO_W'($urandom_range(0, 511));
         if (roll < alloc_w) begin
            f = FN_ALLOC;
         end else if (roll < 84) begin
            f = FN_FREE;
            if (held_pages.size() != 0) begin
               k  = $urandom_range(0, held_pages.size() - 1);
               pg = held_pages[k];
               held_pages.delete(k);
            end else if (lim > int'(fup_reg)) begin
               pg = PAGE_IO_W'($urandom_range(int'(fup_reg), lim - 1));
            end
         end else if (roll < 92) begin
            f = FN_FREE;
         end else if (roll < 95) begin
            f = FN_UNUSED;
         end else if (roll < 98) begin
            f = FN_INIT;
         end else begin
            wait_idle();
            csr_write(CSR_IDX_W'($urandom_range(0, 1)), CFG_W'($urandom_range(0, 1023)));
            f = FN_ALLOC;
         end
         send_item(f, pg, gap_max, 1'b0, '0, r);
         if (f == FN_INIT) held_pages.delete();
         if (f == FN_ALLOC && r.status == ST_OK) held_pages.push_back(r.page_out);
         if ($urandom_range(0, 59) == 0) wait_idle();
      end
   endtask

   initial begin
      alloc_result_type r;
      int               done;
      int               n;
      for (int w = 0; w < NUM_WORDS; w++) free_map[w] = '0;
      free_cnt = '0;
      fup_reg  = '0;
      tot_reg  = 10'd512;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         if (directed_rows[i].kind == RK_CSR) begin
            wait_idle();
            csr_write(directed_rows[i].idx, directed_rows[i].data);
         end else begin
            send_item(directed_rows[i].func, directed_rows[i].page, GAP_MAX,
                      directed_rows[i].fixed, directed_rows[i].want, r);
         end
      end

      done = 0;
      while (done < RAND_ITEMS) begin
         n = $urandom_range(20, 120);
         if (n > RAND_ITEMS - done) n = RAND_ITEMS - done;
         run_phase(n);
         done += n;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d items over %0d register writes", items_sent, csr_writes);
      $display("allocations granted %0d, refused %0d; frees out of range %0d",
               allocs_granted, allocs_refused, frees_rejected);
      if (mismatches == 0 && pending_responses.size() == 0) begin
         $display("bitmap_page_frame_allocator regression: pass");
      end else begin
         $display("bitmap_page_frame_allocator regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
